// ===== sv/obst_pkg.sv =====
// Package for the order book snapshot table: sizes, field widths, codes,
// the stored order word and the controller/datapath interface structs.
// Depends on nothing.
package obst_pkg;

    localparam int INSTRUMENTS          = 4;
    localparam int SLOTS_PER_INSTRUMENT = 8;
    localparam int TABLE_SIZE           = INSTRUMENTS * SLOTS_PER_INSTRUMENT;

    localparam int ENTRY_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int INST_CW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int SLOT_CW = (SLOTS_PER_INSTRUMENT > 1) ? $clog2(SLOTS_PER_INSTRUMENT) : 1;

    localparam int CMD_W    = 3;
    localparam int SEQ_W    = 32;
    localparam int INST_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int PRICE_W  = 32;
    localparam int QTY_W    = 32;
    localparam int PRIO_W   = 32;
    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MODIFY   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SNAPSHOT = 3'd4;

    localparam logic [KIND_W-1:0] KIND_STATUS = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ORDER  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_EXISTS   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_MISSING  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] STS_GAP      = 3'd4;

    typedef struct packed {
        logic                      side;
        logic signed [PRICE_W-1:0] price;
        logic        [QTY_W-1:0]   qty;
        logic        [PRIO_W-1:0]  prio;
    } obst_entry_t;

    localparam int ENTRY_DATA_W = $bits(obst_entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SNAP_START,
        S_CLEAR,
        S_SCAN,
        S_SNAP_END
    } obst_state_t;

    typedef struct packed {
        logic accept;
        logic do_update;
        logic emit_start;
        logic emit_clear;
        logic scan;
        logic emit_end;
    } obst_cmd_t;

    typedef struct packed {
        logic snap_req;
        logic last_slot;
        logic last_inst;
    } obst_stat_t;

endpackage

// ===== sv/obst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module obst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/obst_ctrl.sv =====
// Sequencer for the order book snapshot table: update and snapshot phases.
// Depends on obst_pkg.
module obst_ctrl
    import obst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  obst_stat_t stat,
    output obst_cmd_t  cmd,
    output logic       busy
);

    obst_state_t state_reg;
    obst_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.snap_req ? S_SNAP_START : S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.do_update = 1'b1;
                state_next    = S_IDLE;
            end
            S_SNAP_START:
            begin
                cmd.emit_start = 1'b1;
                state_next     = S_CLEAR;
            end
            S_CLEAR:
            begin
                cmd.emit_clear = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.last_slot)
                begin
                    state_next = stat.last_inst ? S_SNAP_END : S_CLEAR;
                end
            end
            S_SNAP_END:
            begin
                cmd.emit_end = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/obst_dp.sv =====
// Datapath for the order book snapshot table: request capture, order RAM,
// valid flags, sequence check, scan counters and result registers.
// Depends on obst_pkg and obst_ram.
module obst_dp
    import obst_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  obst_cmd_t                  cmd,
    output obst_stat_t                 stat,
    input  logic [CMD_W-1:0]           command,
    input  logic [SEQ_W-1:0]           sequence_req,
    input  logic [INST_W-1:0]          instrument,
    input  logic [SLOT_W-1:0]          slot,
    input  logic                       sell_side,
    input  logic signed [PRICE_W-1:0]  price,
    input  logic [QTY_W-1:0]           quantity,
    input  logic [PRIO_W-1:0]          queue_priority,
    output logic                       strobe,
    output logic [KIND_W-1:0]          kind,
    output logic [INDEX_W-1:0]         snap_index,
    output logic [INST_W-1:0]          out_instrument,
    output logic [SLOT_W-1:0]          out_slot,
    output logic                       out_sell_side,
    output logic signed [PRICE_W-1:0]  out_price,
    output logic [QTY_W-1:0]           out_quantity,
    output logic [PRIO_W-1:0]          out_priority,
    output logic [SEQ_W-1:0]           seq_reference,
    output logic [STATUS_W-1:0]        status,
    output logic                       last
);

    logic [CMD_W-1:0]          req_cmd_reg;
    logic [SEQ_W-1:0]          req_seq_reg;
    logic [INST_W-1:0]         req_inst_reg;
    logic [SLOT_W-1:0]         req_slot_reg;
    logic                      req_side_reg;
    logic signed [PRICE_W-1:0] req_price_reg;
    logic [QTY_W-1:0]          req_qty_reg;
    logic [PRIO_W-1:0]         req_prio_reg;
    logic [ENTRY_W-1:0]        req_entry_reg;

    logic [TABLE_SIZE-1:0]     valid_reg;
    logic [TABLE_SIZE-1:0]     valid_next;
    logic [SEQ_W-1:0]          last_seq_reg;
    logic [SEQ_W-1:0]          last_seq_next;
    logic [INST_CW-1:0]        scan_inst_reg;
    logic [INST_CW-1:0]        scan_inst_next;
    logic [SLOT_CW-1:0]        scan_slot_reg;
    logic [SLOT_CW-1:0]        scan_slot_next;
    logic [ENTRY_W-1:0]        scan_entry_reg;
    logic [ENTRY_W-1:0]        scan_entry_next;
    logic [INDEX_W-1:0]        snap_idx_reg;
    logic [INDEX_W-1:0]        snap_idx_next;

    logic                      strobe_reg;
    logic                      strobe_next;
    logic [KIND_W-1:0]         kind_reg;
    logic [KIND_W-1:0]         kind_next;
    logic [INDEX_W-1:0]        index_reg;
    logic [INDEX_W-1:0]        index_next;
    logic [INST_W-1:0]         o_inst_reg;
    logic [INST_W-1:0]         o_inst_next;
    logic [SLOT_W-1:0]         o_slot_reg;
    logic [SLOT_W-1:0]         o_slot_next;
    logic                      o_side_reg;
    logic                      o_side_next;
    logic signed [PRICE_W-1:0] o_price_reg;
    logic signed [PRICE_W-1:0] o_price_next;
    logic [QTY_W-1:0]          o_qty_reg;
    logic [QTY_W-1:0]          o_qty_next;
    logic [PRIO_W-1:0]         o_prio_reg;
    logic [PRIO_W-1:0]         o_prio_next;
    logic [SEQ_W-1:0]          seq_ref_reg;
    logic [SEQ_W-1:0]          seq_ref_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic                      last_reg;
    logic                      last_next;

    logic [ENTRY_W-1:0]        accept_entry;
    logic [ENTRY_W-1:0]        ram_raddr;
    logic                      ram_we;
    obst_entry_t               ram_wdata;
    logic [ENTRY_DATA_W-1:0]   ram_rdata;
    obst_entry_t               rd_entry;
    logic                      seq_ok;
    logic                      in_range;

    obst_ram #(
        .WIDTH (ENTRY_DATA_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req_entry_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry     = obst_entry_t'(ram_rdata);
    assign accept_entry = ENTRY_W'(int'(instrument) * SLOTS_PER_INSTRUMENT + int'(slot));
    assign seq_ok       = (req_seq_reg == last_seq_reg + 1'b1);
    assign in_range     = (int'(req_inst_reg) < INSTRUMENTS) &&
                          (int'(req_slot_reg) < SLOTS_PER_INSTRUMENT);

    assign stat.snap_req  = (command == CMD_SNAPSHOT);
    assign stat.last_slot = (scan_slot_reg == SLOT_CW'(SLOTS_PER_INSTRUMENT - 1));
    assign stat.last_inst = (scan_inst_reg == INST_CW'(INSTRUMENTS - 1));

    always_comb
    begin
        if (cmd.accept)
        begin
            ram_raddr = accept_entry;
        end
        else if (cmd.emit_clear)
        begin
            ram_raddr = scan_entry_reg;
        end
        else
        begin
            ram_raddr = scan_entry_reg + 1'b1;
        end
    end

    always_comb
    begin
        strobe_next     = 1'b0;
        kind_next       = KIND_STATUS;
        index_next      = '0;
        o_inst_next     = '0;
        o_slot_next     = '0;
        o_side_next     = 1'b0;
        o_price_next    = '0;
        o_qty_next      = '0;
        o_prio_next     = '0;
        seq_ref_next    = '0;
        status_next     = STS_OK;
        last_next       = 1'b0;
        valid_next      = valid_reg;
        last_seq_next   = last_seq_reg;
        scan_inst_next  = scan_inst_reg;
        scan_slot_next  = scan_slot_reg;
        scan_entry_next = scan_entry_reg;
        snap_idx_next   = snap_idx_reg;
        ram_we          = 1'b0;
        ram_wdata       = '{side: req_side_reg, price: req_price_reg,
                            qty: req_qty_reg, prio: req_prio_reg};

        if (cmd.do_update)
        begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
            if (!seq_ok)
            begin
                status_next = STS_GAP;
            end
            else
            begin
                last_seq_next = req_seq_reg;
                if (!(req_cmd_reg inside {CMD_ADD, CMD_MODIFY, CMD_CANCEL}))
                begin
                    status_next = STS_OK;
                end
                else if (!in_range)
                begin
                    status_next = STS_MISSING;
                end
                else if (req_cmd_reg == CMD_ADD)
                begin
                    if (valid_reg[req_entry_reg])
                    begin
                        status_next = STS_EXISTS;
                    end
                    else
                    begin
                        ram_we                    = 1'b1;
                        valid_next[req_entry_reg] = 1'b1;
                    end
                end
                else if (!valid_reg[req_entry_reg])
                begin
                    status_next = STS_MISSING;
                end
                else if (rd_entry.side != req_side_reg)
                begin
                    status_next = STS_MISMATCH;
                end
                else if (req_cmd_reg == CMD_MODIFY)
                begin
                    ram_we         = 1'b1;
                    ram_wdata.side = rd_entry.side;
                    ram_wdata.prio = rd_entry.prio;
                end
                else
                begin
                    valid_next[req_entry_reg] = 1'b0;
                end
            end
        end

        if (cmd.emit_start)
        begin
            strobe_next     = 1'b1;
            kind_next       = KIND_START;
            seq_ref_next    = last_seq_reg;
            snap_idx_next   = INDEX_W'(1);
            scan_inst_next  = '0;
            scan_slot_next  = '0;
            scan_entry_next = '0;
        end

        if (cmd.emit_clear)
        begin
            strobe_next    = 1'b1;
            kind_next      = KIND_CLEAR;
            index_next     = snap_idx_reg;
            o_inst_next    = INST_W'(scan_inst_reg);
            snap_idx_next  = snap_idx_reg + 1'b1;
            scan_slot_next = '0;
        end

        if (cmd.scan)
        begin
            strobe_next     = valid_reg[scan_entry_reg];
            kind_next       = KIND_ORDER;
            index_next      = snap_idx_reg;
            o_inst_next     = INST_W'(scan_inst_reg);
            o_slot_next     = SLOT_W'(scan_slot_reg);
            o_side_next     = rd_entry.side;
            o_price_next    = rd_entry.price;
            o_qty_next      = rd_entry.qty;
            o_prio_next     = rd_entry.prio;
            scan_entry_next = scan_entry_reg + 1'b1;
            if (valid_reg[scan_entry_reg])
            begin
                snap_idx_next = snap_idx_reg + 1'b1;
            end
            if (stat.last_slot)
            begin
                scan_inst_next = scan_inst_reg + 1'b1;
            end
            else
            begin
                scan_slot_next = scan_slot_reg + 1'b1;
            end
        end

        if (cmd.emit_end)
        begin
            strobe_next  = 1'b1;
            kind_next    = KIND_END;
            index_next   = snap_idx_reg;
            seq_ref_next = last_seq_reg;
            last_next    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_cmd_reg   <= command;
            req_seq_reg   <= sequence_req;
            req_inst_reg  <= instrument;
            req_slot_reg  <= slot;
            req_side_reg  <= sell_side;
            req_price_reg <= price;
            req_qty_reg   <= quantity;
            req_prio_reg  <= queue_priority;
            req_entry_reg <= accept_entry;
        end
        kind_reg    <= kind_next;
        index_reg   <= index_next;
        o_inst_reg  <= o_inst_next;
        o_slot_reg  <= o_slot_next;
        o_side_reg  <= o_side_next;
        o_price_reg <= o_price_next;
        o_qty_reg   <= o_qty_next;
        o_prio_reg  <= o_prio_next;
        seq_ref_reg <= seq_ref_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            last_seq_reg   <= '0;
            scan_inst_reg  <= '0;
            scan_slot_reg  <= '0;
            scan_entry_reg <= '0;
            snap_idx_reg   <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            last_seq_reg   <= last_seq_next;
            scan_inst_reg  <= scan_inst_next;
            scan_slot_reg  <= scan_slot_next;
            scan_entry_reg <= scan_entry_next;
            snap_idx_reg   <= snap_idx_next;
            strobe_reg     <= strobe_next;
        end
    end

    assign strobe         = strobe_reg;
    assign kind           = kind_reg;
    assign snap_index     = index_reg;
    assign out_instrument = o_inst_reg;
    assign out_slot       = o_slot_reg;
    assign out_sell_side  = o_side_reg;
    assign out_price      = o_price_reg;
    assign out_quantity   = o_qty_reg;
    assign out_priority   = o_prio_reg;
    assign seq_reference  = seq_ref_reg;
    assign status         = status_reg;
    assign last           = last_reg;

endmodule

// ===== sv/order_book_snapshot_table.sv =====
// Top level of the order book snapshot table.
// Depends on obst_pkg, obst_ctrl and obst_dp.
//
// Usage:
//   A word is taken on a rising edge with start high and busy low. Commands
//   add, modify, cancel and other updates give one status word; a snapshot
//   gives a start marker, a clear marker per instrument followed by its live
//   orders in slot order, and an end marker. Each result word is on the
//   output ports for one cycle with strobe high; last marks the final word.
//   The first result word is registered: it is formed in the state entered
//   at the accepting edge. An update keeps busy high for one cycle, and no
//   word is taken while busy is high. A snapshot keeps busy high through the
//   start state, a clear state and a scan state per instrument, and the end
//   state; the table RAM is read one slot per cycle during the scans.
//   The receiver cannot stall; every word is taken on the cycle it is shown.
//   Reset empties the table at once through per-slot valid flags and sets
//   the last sequence number to zero; no clearing pass is needed.
module order_book_snapshot_table
    import obst_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           command,
    input  logic [SEQ_W-1:0]           sequence_req,
    input  logic [INST_W-1:0]          instrument,
    input  logic [SLOT_W-1:0]          slot,
    input  logic                       sell_side,
    input  logic signed [PRICE_W-1:0]  price,
    input  logic [QTY_W-1:0]           quantity,
    input  logic [PRIO_W-1:0]          queue_priority,
    output logic                       strobe,
    output logic [KIND_W-1:0]          kind,
    output logic [INDEX_W-1:0]         snap_index,
    output logic [INST_W-1:0]          out_instrument,
    output logic [SLOT_W-1:0]          out_slot,
    output logic                       out_sell_side,
    output logic signed [PRICE_W-1:0]  out_price,
    output logic [QTY_W-1:0]           out_quantity,
    output logic [PRIO_W-1:0]          out_priority,
    output logic [SEQ_W-1:0]           seq_reference,
    output logic [STATUS_W-1:0]        status,
    output logic                       last
);

    obst_cmd_t  cmd;
    obst_stat_t stat;

    obst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    obst_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .command        (command),
        .sequence_req   (sequence_req),
        .instrument     (instrument),
        .slot           (slot),
        .sell_side      (sell_side),
        .price          (price),
        .quantity       (quantity),
        .queue_priority (queue_priority),
        .strobe         (strobe),
        .kind           (kind),
        .snap_index     (snap_index),
        .out_instrument (out_instrument),
        .out_slot       (out_slot),
        .out_sell_side  (out_sell_side),
        .out_price      (out_price),
        .out_quantity   (out_quantity),
        .out_priority   (out_priority),
        .seq_reference  (seq_reference),
        .status         (status),
        .last           (last)
    );

endmodule

// ===== sv/obst_checker.sv =====
// Port-level checks for the order book snapshot table, bound to the top level.
// Depends on obst_pkg and order_book_snapshot_table.
module obst_checker
    import obst_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [CMD_W-1:0]           command,
    input logic                       strobe,
    input logic [KIND_W-1:0]          kind,
    input logic [INDEX_W-1:0]         snap_index,
    input logic                       last
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted word");

    a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command != CMD_SNAPSHOT |-> ##2
        (strobe && kind == KIND_STATUS && last))
        else $error("update did not give a final status word");

    a_snap_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == CMD_SNAPSHOT |-> ##2
        (strobe && kind == KIND_START && snap_index == '0 && !last))
        else $error("snapshot did not open with a start marker");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("final word shown while still busy");

    a_order_in_snap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_CLEAR || kind == KIND_ORDER) |-> busy && !last)
        else $error("clear or order word outside a snapshot run");

endmodule

bind order_book_snapshot_table obst_checker u_obst_checker (.*);
